### hw/rtl/ssqm_pkg.sv
package ssqm_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned ServiceBits = 16;
  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CountW = $clog2(QueueDepth + 1);
  localparam int unsigned TickW = 32;

  typedef struct packed {
    logic        arrive_valid;
    logic [15:0] service_ticks;
  } in_req_t;

  typedef struct packed {
    logic        departed;
    logic [31:0] departed_wait;
    logic [31:0] max_wait;
    logic [6:0]  max_length;
    logic [6:0]  queue_count;
    logic        overflow;
  } out_rsp_t;

  typedef struct packed {
    logic                   arrive;
    logic [ServiceBits-1:0] svc;
  } item_t;

endpackage

### hw/rtl/ssqm_front.sv
module ssqm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ssqm_pkg::in_req_t in_req_i,
  output logic              item_valid_o,
  output ssqm_pkg::item_t   item_o,
  input  logic              item_pop_i
);

  ssqm_pkg::item_t slots_q [2];
  logic            wr_q, wr_d;
  logic            rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;
  ssqm_pkg::item_t item_in;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slots_q[rd_q];

  // A request without an arrival carries no service time.
  always_comb begin
    item_in.arrive = in_req_i.arrive_valid;
    item_in.svc    = in_req_i.arrive_valid ?
                     ssqm_pkg::ServiceBits'(in_req_i.service_ticks) : '0;
  end

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = item_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !item_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && item_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_q] <= item_in;
    end
  end

endmodule

### hw/rtl/ssqm_back.sv
module ssqm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  ssqm_pkg::item_t    item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ssqm_pkg::out_rsp_t out_rsp_o
);

  typedef struct packed {
    logic [ssqm_pkg::ServiceBits-1:0] svc;
    logic [ssqm_pkg::TickW-1:0]       tick;
  } slot_t;

  slot_t slot_mem [ssqm_pkg::QueueDepth];
  slot_t rd_q;

  logic [ssqm_pkg::ServiceBits-1:0] head_rem_q, head_rem_d;
  logic [ssqm_pkg::TickW-1:0]       head_wait_q, head_wait_d;
  logic [ssqm_pkg::PtrW-1:0]        rp_q, rp_d, wp_q, wp_d, rd_addr;
  logic [ssqm_pkg::CountW-1:0]      cnt_q, cnt_d, cnt_mid;
  logic [ssqm_pkg::TickW-1:0]       tick_q, tick_d;
  logic [ssqm_pkg::TickW-1:0]       lw_q, lw_d;
  logic [ssqm_pkg::CountW-1:0]      lq_q, lq_d;
  logic                             fire;
  logic                             dep;
  logic [ssqm_pkg::TickW-1:0]       dep_wait;
  logic                             ovf;
  logic                             we;
  slot_t                            wdata;
  logic                             out_valid_q;
  ssqm_pkg::out_rsp_t               out_q;

  function automatic logic [ssqm_pkg::PtrW-1:0] ptr_next(
    input logic [ssqm_pkg::PtrW-1:0] p
  );
    logic [ssqm_pkg::PtrW-1:0] r;
    r = (p == ssqm_pkg::PtrW'(ssqm_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign fire        = item_valid_i && (!out_valid_q || !out_stall_i);
  assign item_pop_o  = fire;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // rd_q always holds the entry just behind the head, so a departure can
  // promote it without waiting for the memory.
  always_comb begin
    head_rem_d  = head_rem_q;
    head_wait_d = head_wait_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    cnt_mid     = cnt_q;
    cnt_d       = cnt_q;
    tick_d      = tick_q;
    lw_d        = lw_q;
    lq_d        = lq_q;
    dep         = 1'b0;
    dep_wait    = '0;
    ovf         = 1'b0;
    we          = 1'b0;
    wdata.svc   = item_i.svc;
    wdata.tick  = tick_q;
    if (fire) begin
      if (cnt_q != '0) begin
        if (head_rem_q <= ssqm_pkg::ServiceBits'(1)) begin
          dep      = 1'b1;
          dep_wait = head_wait_q;
          rp_d     = ptr_next(rp_q);
          cnt_mid  = cnt_q - 1'b1;
          if (cnt_mid != '0) begin
            head_rem_d  = rd_q.svc;
            head_wait_d = (tick_q >= rd_q.tick) ? tick_q - rd_q.tick : '0;
          end else begin
            head_rem_d  = '0;
            head_wait_d = '0;
          end
        end else begin
          head_rem_d = head_rem_q - 1'b1;
        end
      end
      cnt_d = cnt_mid;
      if (item_i.arrive) begin
        if (cnt_mid >= ssqm_pkg::CountW'(ssqm_pkg::QueueDepth)) begin
          ovf = 1'b1;
        end else begin
          we   = 1'b1;
          wp_d = ptr_next(wp_q);
          if (cnt_mid == '0) begin
            head_rem_d  = item_i.svc;
            head_wait_d = '0;
          end
          cnt_d = cnt_mid + 1'b1;
        end
      end
      if (dep && (dep_wait > lw_q)) begin
        lw_d = dep_wait;
      end
      if ((cnt_d >= ssqm_pkg::CountW'(2)) && (cnt_d > lq_q)) begin
        lq_d = cnt_d;
      end
      if (tick_q != '1) begin
        tick_d = tick_q + 1'b1;
      end
    end
    rd_addr = ptr_next(rp_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_rem_q  <= '0;
      head_wait_q <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      tick_q      <= '0;
      lw_q        <= '0;
      lq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_rem_q  <= head_rem_d;
      head_wait_q <= head_wait_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      tick_q      <= tick_d;
      lw_q        <= lw_d;
      lq_q        <= lq_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_mem[wp_q] <= wdata;
    end
    if (we && (wp_q == rd_addr)) begin
      rd_q <= wdata;
    end else begin
      rd_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.departed      <= dep;
      out_q.departed_wait <= dep_wait;
      out_q.max_wait      <= lw_d;
      out_q.max_length    <= 7'(lq_d);
      out_q.queue_count   <= 7'(cnt_d);
      out_q.overflow      <= ovf;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ssqm_pkg::CountW'(ssqm_pkg::QueueDepth))
    else $error("Queue count exceeds the queue depth.");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_rem_q == '0) && (head_wait_q == '0))
    else $error("Empty queue holds a head entry.");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ovf) |=> (cnt_q == ssqm_pkg::CountW'(ssqm_pkg::QueueDepth)))
    else $error("Dropped arrival while the queue was not full.");

  a_max_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.max_wait >= out_q.departed_wait))
    else $error("Largest wait is below the departing wait.");

endmodule

### hw/rtl/single_server_queue_monitor.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o   in_req_i  (ssqm_pkg::in_req_t)
// out      output     out_valid_o / out_stall_i out_rsp_o (ssqm_pkg::out_rsp_t)
//
// Each request is one tick and yields one response; one request per cycle is sustained
// while out_stall_i is low. Requests pass a two-entry queue, then the head update.
// The head update and the single write port of the slot memory set the one-cycle rate.
// Reset clears all counters and pointers; the slot memory needs no clearing.
// A stalled response holds the back end, and the queue then stalls the input.
module single_server_queue_monitor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ssqm_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ssqm_pkg::out_rsp_t out_rsp_o
);

  logic            item_valid;
  logic            item_pop;
  ssqm_pkg::item_t item;

  ssqm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  ssqm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule
